// ----- design/smpq_pkg.sv -----
// shared types and constants for the sorted max priority queue
`timescale 1ns / 1ps
package smpq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_W = 5;
  localparam int STATUS_W = 2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic out_hold;
  } dp_stat_t;

endpackage

// ----- design/smpq_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface smpq_req_if;
  logic valid;
  logic ready;
  logic action;
  logic signed [smpq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface smpq_rsp_if;
  logic valid;
  logic ready;
  logic signed [smpq_pkg::VALUE_W-1:0] front_value;
  logic is_empty;
  logic [smpq_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic [smpq_pkg::STATUS_W-1:0] status;

  modport source (output valid, output front_value, output is_empty, output entry_count,
                  output status, input ready);
  modport sink (input valid, input front_value, input is_empty, input entry_count,
                input status, output ready);
endinterface

// ----- design/smpq_ctrl.sv -----
// controller state machine: capture an item, then run the update
`timescale 1ns / 1ps
module smpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  smpq_req_if.sink            req,
  input  smpq_pkg::dp_stat_t  stat,
  output smpq_pkg::dp_cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign req.ready = (state == S_IDLE);
  assign cmd.load  = req.valid && req.ready;
  assign cmd.exec  = (state == S_EXEC) && !stat.out_hold;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/smpq_datapath.sv -----
// sorted entry array with parallel compare and shift, and result register
`timescale 1ns / 1ps
module smpq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  smpq_pkg::dp_cmd_t                   cmd,
  output smpq_pkg::dp_stat_t                  stat,
  input  logic                                action,
  input  logic signed [smpq_pkg::VALUE_W-1:0] value,
  smpq_rsp_if.source                          rsp
);

  logic                                act_q;
  logic signed [smpq_pkg::VALUE_W-1:0] val_q;
  logic signed [smpq_pkg::VALUE_W-1:0] entries [smpq_pkg::CAPACITY];
  logic signed [smpq_pkg::VALUE_W-1:0] entries_next [smpq_pkg::CAPACITY];
  logic signed [smpq_pkg::VALUE_W-1:0] ins_entries [smpq_pkg::CAPACITY];
  logic signed [smpq_pkg::VALUE_W-1:0] rem_entries [smpq_pkg::CAPACITY];
  logic [smpq_pkg::CAPACITY-1:0]       keep;
  logic [smpq_pkg::CNT_W-1:0]          count;
  logic [smpq_pkg::CNT_W-1:0]          count_next;
  logic [smpq_pkg::STATUS_W-1:0]       status_next;
  logic                                full;
  logic                                empty;
  logic                                out_valid;

  assign full  = (count == smpq_pkg::CNT_W'(smpq_pkg::CAPACITY));
  assign empty = (count == '0);

  // entries that stay in place on insert: valid and not below the new value
  always_comb begin
    for (int i = 0; i < smpq_pkg::CAPACITY; i++) begin
      keep[i] = (smpq_pkg::CNT_W'(i) < count) && (entries[i] >= val_q);
    end
    ins_entries[0] = keep[0] ? entries[0] : val_q;
    for (int i = 1; i < smpq_pkg::CAPACITY; i++) begin
      ins_entries[i] = keep[i] ? entries[i] : (keep[i-1] ? val_q : entries[i-1]);
    end
    for (int i = 0; i < smpq_pkg::CAPACITY - 1; i++) begin
      rem_entries[i] = entries[i+1];
    end
    rem_entries[smpq_pkg::CAPACITY-1] = entries[smpq_pkg::CAPACITY-1];
  end

  always_comb begin
    entries_next = entries;
    count_next   = count;
    status_next  = smpq_pkg::ST_OK;
    if (act_q == smpq_pkg::ACT_INSERT) begin
      if (full) begin
        status_next = smpq_pkg::ST_FULL;
      end else begin
        entries_next = ins_entries;
        count_next   = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = smpq_pkg::ST_EMPTY;
      end else begin
        entries_next = rem_entries;
        count_next   = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      val_q <= value;
    end
    if (cmd.exec) begin
      entries             <= entries_next;
      rsp.front_value     <= (count_next != '0) ? entries_next[0] : '0;
      rsp.is_empty        <= (count_next == '0);
      rsp.entry_count     <= smpq_pkg::ENTRY_COUNT_W'(count_next);
      rsp.status          <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign stat.out_hold = out_valid && !rsp.ready;

endmodule

// ----- design/sorted_max_priority_queue_core.sv -----
// Bounded max-priority queue of signed 32-bit values kept in descending order in a register
// array of smpq_pkg::CAPACITY entries. Each request item (action 0 insert, 1 remove largest)
// yields one response item with the new largest value (0 when empty), an empty flag, the
// entry count and a status (ok, removal from empty, insert dropped when full). An item is
// first captured, then the compare-and-shift across all entries runs and also loads the
// response register; the next item is taken while a response still waits, and the update
// stalls only while the previous response has not been taken.
`timescale 1ns / 1ps
module sorted_max_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  smpq_req_if.sink    req,
  smpq_rsp_if.source  rsp
);

  smpq_pkg::dp_cmd_t  cmd;
  smpq_pkg::dp_stat_t stat;

  smpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  smpq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .action (req.action),
    .value  (req.value),
    .rsp    (rsp)
  );

endmodule

// ----- design/smpq_checker.sv -----
// port-level checks for the sorted max priority queue
`timescale 1ns / 1ps
module smpq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [smpq_pkg::VALUE_W-1:0] front_value,
  input logic                                is_empty,
  input logic [smpq_pkg::ENTRY_COUNT_W-1:0]  entry_count,
  input logic [smpq_pkg::STATUS_W-1:0]       status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_value) && $stable(status)
      && $stable(entry_count))
    else $error("response changed while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> is_empty == (entry_count == '0))
    else $error("empty flag disagrees with count");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> front_value == '0)
    else $error("front value not zero on empty queue");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == smpq_pkg::ST_EMPTY |-> is_empty)
    else $error("removal error with entries stored");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == smpq_pkg::ST_FULL
      |-> entry_count == smpq_pkg::ENTRY_COUNT_W'(smpq_pkg::CAPACITY))
    else $error("insert dropped without full queue");

endmodule

bind sorted_max_priority_queue_core smpq_checker u_smpq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .front_value (rsp.front_value),
  .is_empty    (rsp.is_empty),
  .entry_count (rsp.entry_count),
  .status      (rsp.status)
);
